FILE: rtl/pirci_pkg.sv
// Shared types and codes for the PI regulator with conditional integration.
// Holds the configuration bundle, the integrator stage payload and register indexes.
// No dependencies.
`default_nettype none

package pirci_pkg;

   // Configuration port geometry.
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 16;

   // Register indexes on the configuration port.
   localparam logic [CSR_IDX_W-1:0] REG_FB_HIGH    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_FB_LOW     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_ERR_WINDOW = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_KP_GAIN    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_KI_GAIN    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_DUTY_HIGH  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_DUTY_LOW   = 3'd6;

   // Operation codes carried on the request tuser.
   localparam logic OP_REGULATE = 1'b0;
   localparam logic OP_CLEAR    = 1'b1;

   typedef struct packed {
      logic signed [15:0] fb_high;
      logic signed [15:0] fb_low;
      logic        [15:0] err_window;
      logic        [15:0] kp_gain;
      logic        [15:0] ki_gain;
      logic signed [15:0] duty_high;
      logic signed [15:0] duty_low;
   } cfg_type;

   // Result of the integrator stage for one regulate transaction.
   typedef struct packed {
      logic signed [16:0] err;
      logic signed [31:0] integ;
      logic               active;
   } integ_out_type;

endpackage

`default_nettype wire

FILE: rtl/pirci_csr.sv
// Configuration register file of the PI regulator.
// Depends on pirci_pkg for the register indexes and the cfg_type bundle.
`default_nettype none

module pirci_csr
   import pirci_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type                    cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            REG_FB_HIGH:    cfg_in.fb_high    = $signed(csr_wdata);
            REG_FB_LOW:     cfg_in.fb_low     = $signed(csr_wdata);
            REG_ERR_WINDOW: cfg_in.err_window = csr_wdata;
            REG_KP_GAIN:    cfg_in.kp_gain    = csr_wdata;
            REG_KI_GAIN:    cfg_in.ki_gain    = csr_wdata;
            REG_DUTY_HIGH:  cfg_in.duty_high  = $signed(csr_wdata);
            REG_DUTY_LOW:   cfg_in.duty_low   = $signed(csr_wdata);
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.fb_high    <= 16'sh7FFF;
         cfg_ff.fb_low     <= 16'sh8000;
         cfg_ff.err_window <= 16'hFFFF;
         cfg_ff.kp_gain    <= 16'd256;
         cfg_ff.ki_gain    <= 16'd0;
         cfg_ff.duty_high  <= 16'sh7FFF;
         cfg_ff.duty_low   <= 16'sh8000;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

FILE: rtl/pirci_integ.sv
// Error and integrator stage: forms the error, decides window and direction,
// and keeps the saturating 32-bit integral. Depends on pirci_pkg.
`default_nettype none

module pirci_integ
   import pirci_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               load,
   input  wire logic               op,
   input  wire logic signed [15:0] feedback,
   input  wire logic signed [15:0] setpoint,
   input  cfg_type                 cfg,
   output integ_out_type           stage
);

   logic signed [31:0] integral_ff;
   logic signed [31:0] integral_in;
   integ_out_type      stage_ff;

   logic signed [16:0] err;
   logic        [16:0] mag;
   logic               active;
   logic               allow;
   logic signed [32:0] sum;
   logic signed [31:0] sum_sat;

   always_comb begin
      err    = {setpoint[15], setpoint} - {feedback[15], feedback};
      mag    = err[16] ? 17'(-err) : 17'(err);
      active = (mag <= {1'b0, cfg.err_window});

      // The high-limit rule takes priority when both limits are crossed.
      if (feedback > cfg.fb_high) begin
         allow = err[16];
      end else if (feedback < cfg.fb_low) begin
         allow = !err[16] && (err != 17'sd0);
      end else begin
         allow = 1'b1;
      end

      sum = {integral_ff[31], integral_ff} + {{16{err[16]}}, err};
      if (sum[32] != sum[31]) begin
         sum_sat = sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end else begin
         sum_sat = sum[31:0];
      end

      if (op == OP_CLEAR) begin
         integral_in = 32'sd0;
      end else if (active && allow) begin
         integral_in = sum_sat;
      end else begin
         integral_in = integral_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         integral_ff <= 32'sd0;
      end else if (load) begin
         integral_ff <= integral_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         stage_ff.err    <= err;
         stage_ff.integ  <= integral_in;
         stage_ff.active <= active;
      end
   end

   assign stage = stage_ff;

endmodule

`default_nettype wire

FILE: rtl/pirci_drive.sv
// Drive computation: registered gain products, then sum, shift by eight and
// the two duty clamps into the result register. Depends on pirci_pkg.
`default_nettype none

module pirci_drive
   import pirci_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               mul_load,
   input  wire logic               out_load,
   input  integ_out_type           stage,
   input  cfg_type                 cfg,
   output logic signed [15:0]      duty,
   output logic                    integ_active,
   output logic                    clamped
);

   logic signed [33:0] pprod_ff;
   logic signed [33:0] pprod_in;
   logic signed [48:0] iprod_ff;
   logic signed [48:0] iprod_in;
   logic               act_ff;

   logic signed [49:0] acc;
   logic signed [41:0] shifted;
   logic signed [41:0] hi_ext;
   logic signed [41:0] lo_ext;
   logic signed [41:0] limited;
   logic               clamped_in;

   logic signed [15:0] duty_ff;
   logic               integ_active_ff;
   logic               clamped_ff;

   // Gains are unsigned Q8.8, so they enter the signed products with a zero sign bit.
   always_comb begin
      pprod_in = $signed({1'b0, cfg.kp_gain}) * stage.err;
      iprod_in = stage.active ? $signed({1'b0, cfg.ki_gain}) * stage.integ : 49'sd0;
   end

   always_ff @(posedge clock) begin
      if (mul_load) begin
         pprod_ff <= pprod_in;
         iprod_ff <= iprod_in;
         act_ff   <= stage.active;
      end
   end

   always_comb begin
      acc     = {{16{pprod_ff[33]}}, pprod_ff} + {iprod_ff[48], iprod_ff};
      // Dropping the low eight bits of a two's complement value rounds toward minus infinity.
      shifted = acc[49:8];
      hi_ext  = {{26{cfg.duty_high[15]}}, cfg.duty_high};
      lo_ext  = {{26{cfg.duty_low[15]}}, cfg.duty_low};
      limited    = shifted;
      clamped_in = 1'b0;
      if (limited > hi_ext) begin
         limited    = hi_ext;
         clamped_in = 1'b1;
      end
      if (limited < lo_ext) begin
         limited    = lo_ext;
         clamped_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         duty_ff         <= limited[15:0];
         integ_active_ff <= act_ff;
         clamped_ff      <= clamped_in;
      end
   end

   assign duty         = duty_ff;
   assign integ_active = integ_active_ff;
   assign clamped      = clamped_ff;

endmodule

`default_nettype wire

FILE: rtl/pi_regulator_conditional_integration.sv
// Top level of the PI regulator with conditional integration and anti-windup.
// Instantiates pirci_csr, pirci_integ and pirci_drive; depends on pirci_pkg.
//
//   Channel   Direction  Transaction content
//   req_      in         tuser: op; tdata: feedback [15:0], setpoint [31:16]
//   rsp_      out        tdata: duty [15:0], integ_active [16], clamped [17], zeros above
//   csr_      in         write enable, register index, 16-bit write data
//
// One transaction can be accepted every cycle while rsp_tready keeps the pipeline
// moving. A regulate transaction passes an input register, the integrator stage,
// the product registers and the result register before it is offered. The integral
// loop closes in the single integrator stage, which sets the one-per-cycle rate.
// A clear transaction zeroes the integral in that stage and produces no result.
// Each stage advances when the stage after it is empty or moving, so a waiting
// result does not block new requests until the pipeline is full.
// Reset is synchronous: it empties the pipeline, zeroes the integral, loads
// the register reset values and holds req_tready low.
`default_nettype none

module pi_regulator_conditional_integration
   import pirci_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,

   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [31:0]           req_tdata,   // feedback [15:0], setpoint [31:16]
   input  wire logic                  req_tuser,   // op [0]

   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [23:0]                rsp_tdata,   // duty [15:0], integ_active [16], clamped [17]

   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type       cfg;
   integ_out_type stage;

   // Input register.
   logic               in_valid_ff;
   logic               in_valid_in;
   logic               op_ff;
   logic signed [15:0] feedback_ff;
   logic signed [15:0] setpoint_ff;

   // Valid flags of the later stages.
   logic int_valid_ff;
   logic int_valid_in;
   logic mul_valid_ff;
   logic mul_valid_in;
   logic out_valid_ff;
   logic out_valid_in;

   logic rdy_in;
   logic rdy_int;
   logic rdy_mul;
   logic rdy_out;
   logic in_load;
   logic int_load;
   logic mul_load;
   logic out_load;

   logic signed [15:0] duty;
   logic               integ_active;
   logic               clamped;

   // Ready ripples back from the result register.
   always_comb begin
      rdy_out  = !out_valid_ff || rsp_tready;
      rdy_mul  = !mul_valid_ff || rdy_out;
      rdy_int  = !int_valid_ff || rdy_mul;
      // No request is taken while reset is applied.
      rdy_in   = (!in_valid_ff || rdy_int) && !reset;

      in_load  = req_tvalid  && rdy_in;
      int_load = in_valid_ff && rdy_int;
      mul_load = int_valid_ff && rdy_mul;
      out_load = mul_valid_ff && rdy_out;

      in_valid_in  = rdy_in  ? req_tvalid : in_valid_ff;
      // A clear transaction stops at the integrator and yields no result.
      int_valid_in = rdy_int ? (in_valid_ff && (op_ff == OP_REGULATE)) : int_valid_ff;
      mul_valid_in = rdy_mul ? int_valid_ff : mul_valid_ff;
      out_valid_in = rdy_out ? mul_valid_ff : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         int_valid_ff <= 1'b0;
         mul_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         int_valid_ff <= int_valid_in;
         mul_valid_ff <= mul_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_load) begin
         op_ff       <= req_tuser;
         feedback_ff <= $signed(req_tdata[15:0]);
         setpoint_ff <= $signed(req_tdata[31:16]);
      end
   end

   pirci_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   pirci_integ u_integ (
      .clock    (clock),
      .reset    (reset),
      .load     (int_load),
      .op       (op_ff),
      .feedback (feedback_ff),
      .setpoint (setpoint_ff),
      .cfg      (cfg),
      .stage    (stage)
   );

   pirci_drive u_drive (
      .clock        (clock),
      .mul_load     (mul_load),
      .out_load     (out_load),
      .stage        (stage),
      .cfg          (cfg),
      .duty         (duty),
      .integ_active (integ_active),
      .clamped      (clamped)
   );

   assign req_tready = rdy_in;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {6'd0, clamped, integ_active, duty};

endmodule

`default_nettype wire

FILE: bench/pi_regulator_conditional_integration_tb.sv
// Self-checking testbench for the PI regulator with conditional integration.
// Drives random and directed samples, predicts every duty result and checks it.
// Depends on pirci_pkg and pi_regulator_conditional_integration.
`default_nettype none

module pi_regulator_conditional_integration_tb;
   import pirci_pkg::*;

   // The run is stopped here if the design hangs; the slowest correct run is far shorter.
   localparam int CYCLE_LIMIT = 1_000_000;
   // Extra cycles after the last expected result: a clear transaction produces no result
   // but can still be in the four-stage pipeline when the last result comes out.
   localparam int DRAIN_PAD   = 10;
   // One over the chance that a cycle starts an idle burst; zero means no idling.
   localparam int ODDS_MENU [4] = '{0, 3, 8, 24};
   localparam int CORNERS   [5] = '{-32768, -1, 0, 1, 32767};
   // Length of each run of maximal errors that walks the integral far from zero.
   localparam int SAT_RUN     = 40;

   typedef struct {
      logic               op;
      logic signed [15:0] feedback;
      logic signed [15:0] setpoint;
   } sample_type;

   typedef struct {
      logic signed [15:0] duty;
      logic               integ_active;
      logic               clamped;
   } duty_result_type;

   logic                  clock;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [31:0]           req_tdata  = '0;   // feedback [15:0], setpoint [31:16]
   logic                  req_tuser  = 1'b0; // op [0]
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [23:0]           rsp_tdata;         // duty [15:0], integ_active [16], clamped [17]
   logic                  csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;

   // Samples waiting to be sent; the head is the one on the bus while req_tvalid is high.
   sample_type         sample_q[$];
   // Duty results predicted for accepted regulate transactions, oldest first.
   duty_result_type    expected_duty_q[$];

   // Predictor state: a mirror of the registers and of the stored integral.
   cfg_type            regs;
   logic signed [31:0] integ_acc = '0;

   int src_odds = 0;
   int snk_odds = 0;
   int src_gap  = 0;
   int snk_gap  = 0;
   int mismatch_count = 0;
   int cycle_count    = 0;

   pi_regulator_conditional_integration uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Works out the result of one accepted transaction and updates the integral.
   // The error is exact in 17 bits, the products are exact in 64 bits and the
   // final shift is arithmetic, so it rounds toward minus infinity.
   function automatic void predict_duty(input sample_type s);
      logic signed [16:0] err;
      logic        [16:0] mag;
      logic               active;
      logic               allow;
      logic signed [32:0] sum;
      logic signed [63:0] acc;
      duty_result_type    r;
      if (s.op == OP_CLEAR) begin
         integ_acc = '0;
         return;
      end
      err = $signed(s.setpoint) - $signed(s.feedback);
      mag = err[16] ? -err : err;
      active = (mag <= {1'b0, regs.err_window});
      // The high-limit rule is checked first, so it wins when both limits apply.
      if ($signed(s.feedback) > $signed(regs.fb_high)) begin
         allow = err[16];
      end else if ($signed(s.feedback) < $signed(regs.fb_low)) begin
         allow = !err[16] && (err != 0);
      end else begin
         allow = 1'b1;
      end
      if (active && allow) begin
         sum = $signed(integ_acc) + $signed(err);
         // A carry into the sign bit means the 32-bit sum overflowed; saturate instead.
         if (sum[32] != sum[31]) begin
            integ_acc = sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
         end else begin
            integ_acc = sum[31:0];
         end
      end
      acc = $signed({1'b0, regs.kp_gain}) * err;
      if (active) begin
         acc = acc + $signed({1'b0, regs.ki_gain}) * integ_acc;
      end
      acc = acc >>> 8;
      // The low clamp is applied last, so it wins when the clamps are crossed.
      r.clamped = 1'b0;
      if (acc > $signed(regs.duty_high)) begin
         acc = $signed(regs.duty_high);
         r.clamped = 1'b1;
      end
      if (acc < $signed(regs.duty_low)) begin
         acc = $signed(regs.duty_low);
         r.clamped = 1'b1;
      end
      r.duty = acc[15:0];
      r.integ_active = active;
      expected_duty_q.push_back(r);
   endfunction

   // Random sample shaped to hit the interesting regions: errors inside and on the
   // edge of the window, feedback next to the integration limits, corner values and clears.
   function automatic sample_type pick_sample();
      sample_type s;
      int      mode;
      int      w;
      int      e;
      int      f;
      int      lo;
      int      hi;
      w = regs.err_window;
      s.op = OP_REGULATE;
      s.feedback = 16'($urandom);
      s.setpoint = 16'($urandom);
      mode = $urandom_range(0, 11);
      if (mode == 0) begin
         s.op = OP_CLEAR;
      end else if (mode >= 10) begin
         s.feedback = 16'(CORNERS[$urandom_range(0, 4)]);
         s.setpoint = 16'(CORNERS[$urandom_range(0, 4)]);
      end else if (mode >= 3) begin
         if (mode == 7) begin
            e = w + int'($urandom_range(0, 2)) - 1;
            if ($urandom_range(0, 1) == 1) e = -e;
         end else begin
            e = int'($urandom_range(0, 2 * w)) - w;
         end
         if (e > 65535) e = 65535;
         if (e < -65535) e = -65535;
         lo = (e > 0) ? -32768 : -32768 - e;
         hi = (e > 0) ? 32767 - e : 32767;
         if (mode >= 8) begin
            f = ($urandom_range(0, 1) == 1) ? $signed(regs.fb_high) : $signed(regs.fb_low);
            f = f + int'($urandom_range(0, 4)) - 2;
         end else begin
            f = lo + int'($urandom_range(0, hi - lo));
         end
         if (f < lo) f = lo;
         if (f > hi) f = hi;
         s.feedback = 16'(f);
         s.setpoint = 16'(f + e);
      end
      return s;
   endfunction

   task automatic push_sample(input logic op, input int fb, input int sp);
      sample_type s;
      s.op = op;
      s.feedback = 16'(fb);
      s.setpoint = 16'(sp);
      sample_q.push_back(s);
   endtask

   // Waits until every sample went out and every result came back, then lets the
   // pipeline empty of clear transactions. Ends aligned to a rising edge.
   task automatic drain();
      while (sample_q.size() != 0 || expected_duty_q.size() != 0) @(posedge clock);
      repeat (DRAIN_PAD) @(posedge clock);
   endtask

   // One register write; the mirror follows once the write edge has passed.
   task automatic put_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         REG_FB_HIGH:    regs.fb_high    = val;
         REG_FB_LOW:     regs.fb_low     = val;
         REG_ERR_WINDOW: regs.err_window = val;
         REG_KP_GAIN:    regs.kp_gain    = val;
         REG_KI_GAIN:    regs.ki_gain    = val;
         REG_DUTY_HIGH:  regs.duty_high  = val;
         REG_DUTY_LOW:   regs.duty_low   = val;
         default: ;
      endcase
   endtask

   // Writes all seven registers back to back; only called with the block idle.
   task automatic program_regs(input int fbh, input int fbl, input int win, input int kp,
                               input int ki, input int dh, input int dl);
      put_reg(REG_FB_HIGH,    16'(fbh));
      put_reg(REG_FB_LOW,     16'(fbl));
      put_reg(REG_ERR_WINDOW, 16'(win));
      put_reg(REG_KP_GAIN,    16'(kp));
      put_reg(REG_KI_GAIN,    16'(ki));
      put_reg(REG_DUTY_HIGH,  16'(dh));
      put_reg(REG_DUTY_LOW,   16'(dl));
      csr_we <= 1'b0;
   endtask

   // A run of random samples under the current settings, with its own idling mix.
   task automatic regulate_burst(input int n);
      src_odds = ODDS_MENU[$urandom_range(0, 3)];
      snk_odds = ODDS_MENU[$urandom_range(0, 3)];
      repeat (n) sample_q.push_back(pick_sample());
      drain();
   endtask

   // Request driver. The head of sample_q is offered; it is predicted and dropped
   // at the edge where the transaction is accepted. Once raised, req_tvalid stays
   // high with steady data until the transaction goes through.
   always @(posedge clock) begin
      logic offer;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            predict_duty(sample_q[0]);
            void'(sample_q.pop_front());
         end
         offer = 1'b0;
         if (req_tvalid && !req_tready) begin
            offer = 1'b1;
         end else if (src_gap > 0) begin
            src_gap--;
         end else if (sample_q.size() != 0) begin
            if (src_odds != 0 && $urandom_range(0, src_odds - 1) == 0) begin
               src_gap = $urandom_range(0, 17);
            end else begin
               offer = 1'b1;
            end
         end
         req_tvalid <= offer;
         if (offer) begin
            req_tdata <= {sample_q[0].setpoint, sample_q[0].feedback};
            req_tuser <= sample_q[0].op;
         end
      end
   end

   // Result sink: rsp_tready drops in random bursts while the phase asks for it.
   always @(posedge clock) begin
      logic take;
      take = 1'b1;
      if (snk_gap > 0) begin
         snk_gap--;
         take = 1'b0;
      end else if (snk_odds != 0 && $urandom_range(0, snk_odds - 1) == 0) begin
         snk_gap = $urandom_range(0, 17);
         take = 1'b0;
      end
      rsp_tready <= take;
   end

   // Result monitor: every accepted result is checked against the oldest prediction.
   always @(posedge clock) begin
      duty_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_duty_q.size() == 0) begin
            $error("result transaction with nothing expected: tdata %h", rsp_tdata);
            mismatch_count++;
         end else begin
            want = expected_duty_q.pop_front();
            if (rsp_tdata[15:0] !== want.duty) begin
               $error("duty: expected %0d, got %0d", want.duty, $signed(rsp_tdata[15:0]));
               mismatch_count++;
            end
            if (rsp_tdata[16] !== want.integ_active) begin
               $error("integ_active: expected %0d, got %0d", want.integ_active, rsp_tdata[16]);
               mismatch_count++;
            end
            if (rsp_tdata[17] !== want.clamped) begin
               $error("clamped: expected %0d, got %0d", want.clamped, rsp_tdata[17]);
               mismatch_count++;
            end
         end
      end
   end

   // Watchdog against a hung handshake.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("pi_regulator_conditional_integration_tb failed");
         $finish;
      end
   end

   initial begin
      regs.fb_high    = 16'sh7FFF;
      regs.fb_low     = 16'sh8000;
      regs.err_window = 16'hFFFF;
      regs.kp_gain    = 16'd256;
      regs.ki_gain    = 16'd0;
      regs.duty_high  = 16'sh7FFF;
      regs.duty_low   = 16'sh8000;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed part. First the widest errors and a clear under the reset settings.
      push_sample(OP_REGULATE, -32768, 32767);
      push_sample(OP_REGULATE, 32767, -32768);
      push_sample(OP_CLEAR, 0, 0);
      drain();

      // Narrow window with limits on both sides of zero and a live integral term.
      program_regs(1000, -1000, 2000, 256, 128, 30000, -30000);
      push_sample(OP_REGULATE, 0, 0);
      push_sample(OP_REGULATE, 0, 500);
      push_sample(OP_REGULATE, 0, 2000);    // error right on the window edge
      push_sample(OP_REGULATE, 0, 2001);    // just outside: term off, sum held
      push_sample(OP_REGULATE, 5000, 4500); // above the high limit, negative error adds
      push_sample(OP_REGULATE, 5000, 5500); // above the high limit, positive error blocked
      push_sample(OP_REGULATE, -5000, -4500);
      push_sample(OP_REGULATE, -5000, -5500);
      push_sample(OP_CLEAR, -1, -1);
      push_sample(OP_REGULATE, 0, -100);
      drain();

      // Limits crossed so both rules apply at once, clamps crossed, full gains.
      program_regs(-100, 100, 65535, 65535, 65535, -500, 500);
      push_sample(OP_REGULATE, 0, 10);
      push_sample(OP_REGULATE, 0, -10);
      push_sample(OP_REGULATE, 32767, 32767);
      push_sample(OP_REGULATE, -32768, -32768);
      push_sample(OP_CLEAR, 32767, -32768);
      push_sample(OP_REGULATE, -32768, 32767);
      drain();

      // Zero window: only a zero error keeps the integral term; zero gains.
      program_regs(32767, -32768, 0, 0, 0, 32767, -32768);
      push_sample(OP_REGULATE, 7, 7);
      push_sample(OP_REGULATE, 7, 8);
      push_sample(OP_REGULATE, 7, 6);
      drain();

      // Random part over a spread of settings, the extremes among them.
      program_regs(32767, -32768, 65535, 256, 0, 32767, -32768);
      regulate_burst(200);
      program_regs(8000, -8000, 4000, 256, 256, 20000, -20000);
      regulate_burst(250);
      program_regs(-32768, 32767, 65535, 65535, 65535, 32767, -32768);
      regulate_burst(150);
      program_regs(32767, -32768, 300, 0, 65535, 1000, -1000);
      regulate_burst(150);
      repeat (4) begin
         program_regs($urandom, $urandom, $urandom_range(0, 3000), $urandom_range(0, 1024),
                      $urandom_range(0, 512), $urandom, $urandom);
         regulate_burst(150);
      end
      program_regs($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      regulate_burst(150);

      // Last part, without idling: walk the integral far out in both directions
      // with maximal errors, with only the integral gain on, back to back.
      src_odds = 0;
      snk_odds = 0;
      program_regs(32767, -32768, 65535, 0, 1, 32767, -32768);
      push_sample(OP_CLEAR, 0, 0);
      repeat (SAT_RUN) push_sample(OP_REGULATE, -32768, 32767);
      repeat (40) sample_q.push_back(pick_sample());
      push_sample(OP_CLEAR, 0, 0);
      repeat (SAT_RUN) push_sample(OP_REGULATE, 32767, -32768);
      repeat (40) sample_q.push_back(pick_sample());
      drain();

      if (mismatch_count == 0) begin
         $display("pi_regulator_conditional_integration_tb passed");
      end else begin
         $display("pi_regulator_conditional_integration_tb failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
